>>> rtl/core/lfbp_pkg.sv
// ----------------------------------------------------------------------------
// lfbp_pkg: shared definitions for the LED frame buffer plotter
// Command, kind and status codes, color masks, default plane size and the
// RGB565 widening function.
// ----------------------------------------------------------------------------
package lfbp_pkg;

    // Default plane size
    localparam int PLANE_WIDTH_DEF  = 8;
    localparam int PLANE_HEIGHT_DEF = 8;

    // Command codes (slave tuser)
    localparam logic [1:0] CMD_DRAW_565 = 2'd0;
    localparam logic [1:0] CMD_DRAW_888 = 2'd1;
    localparam logic [1:0] CMD_FILL_565 = 2'd2;
    localparam logic [1:0] CMD_FLUSH    = 2'd3;

    // Result kind codes (master tuser)
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Draw status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_OUT_RANGE = 1'b1;

    // RGB565 component masks
    localparam logic [15:0] MASK_RED   = 16'hF800;
    localparam logic [15:0] MASK_GREEN = 16'h07E0;
    localparam logic [15:0] MASK_BLUE  = 16'h001F;

    // Stored pixel: green 23-16, red 15-8, blue 7-0
    typedef logic [23:0] grb_t;

    // Widen RGB565 to 8-bit components by a left shift with zero fill
    function automatic grb_t widen_565(input logic [15:0] color);
        logic [15:0] r_m;
        logic [15:0] g_m;
        logic [15:0] b_m;
        r_m = color & MASK_RED;
        g_m = color & MASK_GREEN;
        b_m = color & MASK_BLUE;
        return {g_m[10:5], 2'b00, r_m[15:11], 3'b000, b_m[4:0], 3'b000};
    endfunction

endpackage

>>> rtl/core/led_frame_buffer_plotter.sv
// ----------------------------------------------------------------------------
// led_frame_buffer_plotter: frame buffer for an addressable LED plane
// Stores one green-red-blue triple per pixel in a synchronous memory, takes
// draw, fill and flush requests and streams out draw status and pixels.
//
//  Channel  Dir  Signals                          Request
//  -------  ---  -------------------------------  ----------------------------
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  one command
//  m_*      out  m_tvalid m_tready m_tdata m_tuser  one status or one pixel
//                m_tlast
//
//  Draws can follow each other every cycle while the output is not stalled.
//  A fill sweeps the memory write port, one pixel a cycle, over all W*H pixels.
//  A flush reads one pixel a cycle through the registered memory read port
//  while the output is not stalled.
//  Reset clears a valid bit per pixel at once; an unwritten pixel reads zero.
//  A stall on m_tready holds the output register and the pending read.
// ----------------------------------------------------------------------------
module led_frame_buffer_plotter
    import lfbp_pkg::*;
#(
    parameter int PLANE_WIDTH  = PLANE_WIDTH_DEF,
    parameter int PLANE_HEIGHT = PLANE_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // column[7:0], row[15:8], color_565[31:16], red_in[39:32],
    // green_in[47:40], blue_in[55:48]
    input  logic [55:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], green_out[8:1], red_out[16:9], blue_out[24:17], zero[31:25]
    output logic [31:0] m_tdata,
    // kind[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int DEPTH = PLANE_WIDTH * PLANE_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FILL  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Input fields
    logic [1:0]  command;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] color_565;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;

    assign command   = s_tuser;
    assign column    = s_tdata[7:0];
    assign row       = s_tdata[15:8];
    assign color_565 = s_tdata[31:16];
    assign red_in    = s_tdata[39:32];
    assign green_in  = s_tdata[47:40];
    assign blue_in   = s_tdata[55:48];

    // State
    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    grb_t             fill_grb_reg, fill_grb_next;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_vld_reg, rd_vld_next;
    logic             rd_last_reg;
    logic             rd_hit_reg;
    grb_t             mem_q;
    grb_t             mem [DEPTH];

    logic             out_vld_reg, out_vld_next;
    logic             out_kind_reg;
    logic             out_status_reg;
    grb_t             out_grb_reg;
    logic             out_last_reg;

    // Control
    logic          s_acc;
    logic          out_free;
    logic          is_draw;
    logic          draw_acc;
    logic          in_range;
    logic          pix_load;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    grb_t          wr_data;
    grb_t          draw_grb;
    logic [7:0]    sx;
    logic [15:0]   draw_addr_full;

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !rd_vld_reg && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign is_draw  = (command == CMD_DRAW_565) || (command == CMD_DRAW_888);
    assign draw_acc = s_acc && is_draw;
    assign in_range = (column < 8'(PLANE_WIDTH)) && (row < 8'(PLANE_HEIGHT));
    assign pix_load = rd_vld_reg && out_free;
    assign rd_en    = (state_reg == ST_FLUSH) && (!rd_vld_reg || pix_load);

    // Mirror the column and form the stored address
    assign sx             = 8'(PLANE_WIDTH - 1) - column;
    assign draw_addr_full = 16'(sx) * 16'(PLANE_HEIGHT) + 16'(row);
    assign draw_grb       = (command == CMD_DRAW_565) ? widen_565(color_565)
                                                      : {green_in, red_in, blue_in};

    // Select the single write port between draw and fill sweep
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = fill_grb_reg;
        if (state_reg == ST_FILL)
        begin
            wr_en = 1'b1;
        end
        else if (draw_acc && in_range)
        begin
            wr_en   = 1'b1;
            wr_addr = draw_addr_full[AW-1:0];
            wr_data = draw_grb;
        end
    end

    // Sequence fill and flush sweeps
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fill_grb_next = fill_grb_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && command == CMD_FILL_565)
                begin
                    state_next    = ST_FILL;
                    cnt_next      = '0;
                    fill_grb_next = widen_565(color_565);
                end
                else if (s_acc && command == CMD_FLUSH)
                begin
                    state_next = ST_FLUSH;
                    cnt_next   = '0;
                end
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_ADDR)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the pending read and the output register
    always_comb
    begin
        if (rd_en)
            rd_vld_next = 1'b1;
        else if (pix_load)
            rd_vld_next = 1'b0;
        else
            rd_vld_next = rd_vld_reg;

        if (draw_acc || pix_load)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            valid_reg   <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_hit_reg <= valid_reg[cnt_reg];
        end
    end

    // Pixel memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            mem_q       <= mem[cnt_reg];
            rd_last_reg <= (cnt_reg == LAST_ADDR);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_grb_reg <= fill_grb_next;
        if (draw_acc)
        begin
            out_kind_reg   <= KIND_STATUS;
            out_status_reg <= in_range ? STATUS_OK : STATUS_OUT_RANGE;
            out_grb_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else if (pix_load)
        begin
            out_kind_reg   <= KIND_PIXEL;
            out_status_reg <= STATUS_OK;
            out_grb_reg    <= rd_hit_reg ? mem_q : '0;
            out_last_reg   <= rd_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_grb_reg[7:0], out_grb_reg[15:8], out_grb_reg[23:16],
                       out_status_reg};

    // Assertions
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("command accepted during a sweep");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_PIXEL))
        else $error("last set on a status result");

    a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg && !pix_load) |=> (rd_vld_reg && $stable(mem_q)))
        else $error("pending pixel read lost during stall");

    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && cnt_reg == LAST_ADDR) |=> (state_reg == ST_IDLE))
        else $error("fill sweep did not end on the last pixel");

endmodule

>>> test/led_frame_buffer_plotter_test.sv
// ----------------------------------------------------------------------------
// led_frame_buffer_plotter_test: self-checking bench for the LED frame buffer
// Streams draw, fill and flush requests into the plotter. The sender works in
// bursts with random gaps, and the receiver stalls on a rotating pattern.
// A local copy of the pixel memory predicts every draw status and every
// flushed pixel, and each returned request is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module led_frame_buffer_plotter_test
    import lfbp_pkg::*;
;

    localparam int PW          = PLANE_WIDTH_DEF;
    localparam int PH          = PLANE_HEIGHT_DEF;
    localparam int PIXELS      = PW * PH;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 2 * PIXELS + 16;
    localparam int RANDOM_REQS = 98;

    // One command as it goes into the slave channel
    typedef struct {
        logic [1:0]  command;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [15:0] color_565;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        bit          wait_drain;
    } plot_req_t;

    // One status or pixel as it leaves the master channel
    typedef struct {
        logic       kind;
        logic       status;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last;
    } led_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    plot_req_t   commands_to_send[$];
    led_result_t results_due[$];
    grb_t        frame_model[PIXELS];
    plot_req_t   in_flight;

    int          burst_left;
    int          gap_left;
    logic [15:0] stall_pattern;
    int          pattern_age;
    int          idle_cycles;
    int          error_count;
    int          results_seen;
    int          draws_sent;
    int          misses_sent;
    int          fills_sent;
    int          flushes_sent;

    led_frame_buffer_plotter #(
        .PLANE_WIDTH  (PW),
        .PLANE_HEIGHT (PH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply the frame buffer update of one accepted command and queue its results
    function automatic void plot_command(input plot_req_t req);
        grb_t        color;
        int          slot;
        led_result_t res;
        color = {req.color_565[10:5], 2'b00, req.color_565[15:11], 3'b000,
                 req.color_565[4:0], 3'b000};
        res = '{kind: KIND_STATUS, status: STATUS_OK, green: 8'd0, red: 8'd0,
                blue: 8'd0, last: 1'b0};
        case (req.command)
            CMD_DRAW_565, CMD_DRAW_888:
            begin
                if (req.column >= PW || req.row >= PH)
                begin
                    res.status = STATUS_OUT_RANGE;
                    misses_sent++;
                end
                else
                begin
                    // mirror the column before storing
                    slot = (PW - 1 - int'(req.column)) * PH + int'(req.row);
                    if (req.command == CMD_DRAW_888)
                        color = {req.green_in, req.red_in, req.blue_in};
                    frame_model[slot] = color;
                end
                draws_sent++;
                results_due.push_back(res);
            end
            CMD_FILL_565:
            begin
                foreach (frame_model[i])
                    frame_model[i] = color;
                fills_sent++;
            end
            default:
            begin
                res.kind = KIND_PIXEL;
                foreach (frame_model[i])
                begin
                    res.green = frame_model[i][23:16];
                    res.red   = frame_model[i][15:8];
                    res.blue  = frame_model[i][7:0];
                    res.last  = (i == PIXELS - 1);
                    results_due.push_back(res);
                end
                flushes_sent++;
            end
        endcase
    endfunction

    // Queue one command; fields the command ignores still carry whatever is given
    task automatic push_command(input logic [1:0] command, input logic [7:0] column,
                                input logic [7:0] row, input logic [15:0] color_565,
                                input logic [7:0] red_in, input logic [7:0] green_in,
                                input logic [7:0] blue_in, input bit wait_drain);
        plot_req_t req;
        req = '{command: command, column: column, row: row, color_565: color_565,
                red_in: red_in, green_in: green_in, blue_in: blue_in,
                wait_drain: wait_drain};
        commands_to_send.push_back(req);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Driver: present commands in bursts, hold a request while it is stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= CMD_DRAW_565;
            burst_left = $urandom_range(1, 20);
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                plot_command(in_flight);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (commands_to_send.size() > 0 &&
                         (!commands_to_send[0].wait_drain || results_due.size() == 0))
                begin
                    in_flight = commands_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= in_flight.command;
                    s_tdata  <= {in_flight.blue_in, in_flight.green_in, in_flight.red_in,
                                 in_flight.color_565, in_flight.row, in_flight.column};
                    // close the burst and pick the next gap
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotate a stall pattern, renewed when its age counter runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            stall_pattern = 16'hFFFF;
            pattern_age   = 0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0101);
                pattern_age   = $urandom_range(16, 96);
            end
            else
                pattern_age--;
            m_tready      <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // Monitor: compare each returned request with the oldest prediction
    always @(posedge clk)
    begin
        led_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                $error("result with nothing predicted: kind %0h tdata %0h last %0h",
                       m_tuser, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("status", want.status, m_tdata[0]);
                check_field("green_out", want.green, m_tdata[8:1]);
                check_field("red_out", want.red, m_tdata[16:9]);
                check_field("blue_out", want.blue, m_tdata[24:17]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Watchdog: stop when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles, %0d results pending",
                         IDLE_LIMIT, results_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int        pick;
        logic [1:0] cmd;
        logic [7:0] col;
        logic [7:0] row;
        rst_n        = 1'b0;
        idle_cycles  = 0;
        error_count  = 0;
        results_seen = 0;
        draws_sent   = 0;
        misses_sent  = 0;
        fills_sent   = 0;
        flushes_sent = 0;
        foreach (frame_model[i])
            frame_model[i] = '0;

        // Directed: cleared plane, corners, pure colors, misses, fills
        push_command(CMD_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        push_command(CMD_DRAW_565, 8'd0, 8'd0, 16'hFFFF, 8'($urandom), 8'($urandom),
                     8'($urandom), 1'b0);
        push_command(CMD_DRAW_565, 8'd7, 8'd7, 16'h0000, 8'($urandom), 8'($urandom),
                     8'($urandom), 1'b0);
        push_command(CMD_DRAW_565, 8'd1, 8'd2, MASK_RED, 8'h00, 8'hFF, 8'h00, 1'b0);
        push_command(CMD_DRAW_565, 8'd2, 8'd3, MASK_GREEN, 8'hFF, 8'h00, 8'hFF, 1'b0);
        push_command(CMD_DRAW_565, 8'd3, 8'd4, MASK_BLUE, 8'h55, 8'hAA, 8'h55, 1'b0);
        push_command(CMD_DRAW_888, 8'd7, 8'd0, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_command(CMD_DRAW_888, 8'd0, 8'd7, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        push_command(CMD_DRAW_888, 8'd4, 8'd6, 16'h1234, 8'h12, 8'h34, 8'h56, 1'b0);
        push_command(CMD_DRAW_565, 8'd8, 8'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_command(CMD_DRAW_888, 8'd0, 8'd8, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_command(CMD_DRAW_565, 8'd255, 8'd255, 16'hABCD, 8'h01, 8'h02, 8'h03, 1'b0);
        push_command(CMD_DRAW_888, 8'd255, 8'd0, 16'h0000, 8'hAA, 8'hBB, 8'hCC, 1'b0);
        push_command(CMD_FLUSH, 8'd0, 8'd0, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1);
        push_command(CMD_FILL_565, 8'd200, 8'd200, 16'hFFFF, 8'($urandom), 8'($urandom),
                     8'($urandom), 1'b0);
        push_command(CMD_DRAW_888, 8'd5, 8'd1, 16'h0000, 8'h01, 8'h80, 8'h7F, 1'b0);
        push_command(CMD_FLUSH, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_command(CMD_FILL_565, 8'd0, 8'd0, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_command(CMD_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        push_command(CMD_FILL_565, 8'($urandom), 8'($urandom), 16'hA5C3,
                     8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        push_command(CMD_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        // Random: mostly in-range draws, an occasional fill or flush
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                cmd = CMD_FLUSH;
            else if (pick < 11)
                cmd = CMD_FILL_565;
            else if (pick < 55)
                cmd = CMD_DRAW_565;
            else
                cmd = CMD_DRAW_888;
            if ($urandom_range(0, 99) < 85)
            begin
                col = 8'($urandom_range(0, PW - 1));
                row = 8'($urandom_range(0, PH - 1));
            end
            else
            begin
                col = 8'($urandom);
                row = 8'($urandom);
            end
            push_command(cmd, col, row, 16'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), $urandom_range(0, 9) == 0);
        end
        push_command(CMD_FLUSH, 8'($urandom), 8'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        // Release reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every command to go in and every result to come out
        @(posedge clk);
        while (commands_to_send.size() > 0 || s_tvalid)
            @(posedge clk);
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (results_due.size() > 0)
        begin
            $error("%0d predicted results never arrived", results_due.size());
            error_count++;
        end

        $display("Covered %0d draws (%0d off the plane), %0d fills and %0d flushes",
                 draws_sent, misses_sent, fills_sent, flushes_sent);
        $display("Compared %0d returned requests, %0d field mismatches",
                 results_seen, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
